// ----- rtl/crlf_pkg.sv -----
// Shared constants and types of the CRLF line-ending normalizer.
`default_nettype none

package crlf_pkg;

   // Width of the byte counter and the capacity register
   localparam int COUNT_W = 16;
   // Width of the reported written count
   localparam int WCOUNT_W = 16;

   // Line-ending characters
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Most bytes one input word can produce
   localparam int MAX_BYTES = 4;
   localparam int NUM_W = $clog2(MAX_BYTES + 1);
   localparam int IDX_W = $clog2(MAX_BYTES);

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // Result word packing
   localparam int RSP_FIELDS_W = 8 + 1 + 2 + WCOUNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Stream status codes
   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   // Scan phase of a stream
   typedef enum logic [1:0] {
      PH_SCAN = 2'd0,
      PH_PASS = 2'd1,
      PH_CONV = 2'd2
   } crlf_phase_type;

   // One classified input word, as queued for the back end
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [NUM_W-1:0]          num;
      logic                      last;
      logic [1:0]                status;
      logic [WCOUNT_W-1:0]       count;
   } crlf_entry_type;

   // One result word
   typedef struct packed {
      logic [7:0]          out_byte;
      logic                byte_valid;
      logic                run_last;
      logic                stream_end;
      logic [1:0]          status;
      logic [WCOUNT_W-1:0] written_count;
   } crlf_result_type;

endpackage

`default_nettype wire

// ----- rtl/crlf_front.sv -----
// Front end: accepts input words, tracks line-ending state and classifies each word.
`default_nettype none

module crlf_front import crlf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   output logic               in_ready,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata,
   input  logic               q_full,
   output logic               push,
   output crlf_entry_type     push_entry
);

   crlf_phase_type     phase_ff, phase_in, phase_nxt;
   logic               held_ff, held_in, held_nxt;
   logic [COUNT_W-1:0] count_ff, count_in, count_nxt;
   logic               ovf_ff, ovf_in, ovf_nxt;
   logic [COUNT_W-1:0] cap_ff, cap_in;

   logic                      accept;
   logic                      is_cr, is_lf;
   logic                      prefix;
   logic [1:0]                tail_n;
   logic                      tail_crlf;
   logic [7:0]                t0, t1;
   logic [MAX_BYTES-1:0][7:0] raw;
   logic [NUM_W-1:0]          n_raw;
   logic [COUNT_W:0]          diff;
   logic [NUM_W-1:0]          avail;
   logic                      over;
   logic [NUM_W-1:0]          num;
   logic [1:0]                status;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign is_cr    = (in_byte == CH_CR);
   assign is_lf    = (in_byte == CH_LF);

   // Register state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SCAN;
         held_ff  <= 1'b0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         cap_ff   <= '1;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         cap_ff   <= cap_in;
      end
   end

   // Classify the word: optional CR LF for a held CR, then the tail
   always_comb begin
      prefix    = 1'b0;
      tail_n    = 2'd1;
      tail_crlf = 1'b0;
      held_nxt  = 1'b0;
      phase_nxt = phase_ff;
      case (phase_ff)
         PH_SCAN, PH_CONV: begin
            prefix = held_ff;
            if (held_ff && is_lf) begin
               tail_n = 2'd0;
            end else if (is_cr && !in_last) begin
               tail_n   = 2'd0;
               held_nxt = 1'b1;
            end else if (is_cr || is_lf) begin
               tail_n    = 2'd2;
               tail_crlf = 1'b1;
            end
            if (phase_ff == PH_SCAN) begin
               if (held_ff) begin
                  phase_nxt = is_lf ? PH_PASS : PH_CONV;
               end else if (is_lf || (is_cr && in_last)) begin
                  phase_nxt = PH_CONV;
               end
            end
         end
         default: begin
            tail_n = 2'd1;
         end
      endcase
   end

   // Build the byte list
   always_comb begin
      t0 = tail_crlf ? CH_CR : in_byte;
      t1 = tail_crlf ? CH_LF : 8'h00;
      if (prefix) begin
         raw = {t1, t0, CH_LF, CH_CR};
      end else begin
         raw = {8'h00, 8'h00, t1, t0};
      end
      n_raw = NUM_W'({prefix, 1'b0}) + NUM_W'(tail_n);
   end

   // Clamp against the remaining capacity
   always_comb begin
      diff = {1'b0, cap_ff} - {1'b0, count_ff};
      if (diff[COUNT_W]) begin
         avail = '0;
      end else if (diff >= (COUNT_W+1)'(MAX_BYTES)) begin
         avail = NUM_W'(MAX_BYTES);
      end else begin
         avail = diff[NUM_W-1:0];
      end
      over      = (n_raw > avail);
      num       = ovf_ff ? '0 : (over ? avail : n_raw);
      ovf_nxt   = ovf_ff || over;
      count_nxt = count_ff + COUNT_W'(num);
      if (ovf_nxt) begin
         status = ST_OVF;
      end else if (phase_nxt == PH_CONV) begin
         status = ST_CONV;
      end else begin
         status = ST_NONE;
      end
   end

   // Advance stream state on accept, clear it at stream end; csr_we loads the capacity
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      cap_in   = csr_we ? csr_wdata : cap_ff;
      if (accept) begin
         if (in_last) begin
            phase_in = PH_SCAN;
            held_in  = 1'b0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            phase_in = phase_nxt;
            held_in  = held_nxt;
            count_in = count_nxt;
            ovf_in   = ovf_nxt;
         end
      end
   end

   // Queue the word when it yields a result
   assign push              = accept && ((num != '0) || in_last);
   assign push_entry.bytes  = raw;
   assign push_entry.num    = num;
   assign push_entry.last   = in_last;
   assign push_entry.status = status;
   assign push_entry.count  = WCOUNT_W'(count_nxt);

endmodule

`default_nettype wire

// ----- rtl/crlf_queue.sv -----
// Short register queue between the front and back ends.
`default_nettype none

module crlf_queue import crlf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  crlf_entry_type push_entry,
   input  logic           pop,
   output logic           full,
   output logic           head_valid,
   output crlf_entry_type head
);

   crlf_entry_type    mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full       = (fill_ff == (QPTR_W+1)'(QDEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/crlf_back.sv -----
// Back end: expands queued entries into result words through an output register.
`default_nettype none

module crlf_back import crlf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  crlf_entry_type  head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output crlf_result_type rsp
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   crlf_result_type  rsp_ff, rsp_in;
   logic             load;
   logic             final_word;
   logic             has_data;

   assign load       = head_valid && (!valid_ff || rsp_ready);
   assign has_data   = (head.num != '0);
   assign final_word = !has_data || ({1'b0, idx_ff} == (head.num - 1'b1));
   assign pop        = load && final_word;
   assign rsp_valid  = valid_ff;
   assign rsp        = rsp_ff;

   // Pick the next word of the head entry
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_word ? '0 : idx_ff + 1'b1;
         rsp_in.out_byte      = has_data ? head.bytes[idx_ff] : 8'h00;
         rsp_in.byte_valid    = has_data;
         rsp_in.run_last      = final_word;
         rsp_in.stream_end    = final_word && head.last;
         rsp_in.status        = (final_word && head.last) ? head.status : ST_NONE;
         rsp_in.written_count = (final_word && head.last) ? head.count : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold payload until taken
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- rtl/crlf_line_ending_normalizer_unit.sv -----
// Top level of the CRLF line-ending normalizer.
//
// Input words (req_) carry one text byte and tlast on the final byte of a stream.
// The block copies bytes until the first line ending; if that is CR LF the rest
// passes unchanged, otherwise every CR, LF or CR LF from there on goes out as CR LF.
// A CR is held for one word to see whether an LF follows it.
// Result words (rsp_) carry one output byte each (tuser high) and a run-last bit on
// the final word caused by one input word. The final word of a stream has tlast high
// and carries the status (0 unchanged, 1 converted, 2 overflow) and the byte count;
// when that input word sends no byte, a status-only word with tuser low is sent.
// csr_ writes the output capacity (reset 65535); bytes beyond it are dropped.
// An accepted input word is registered in the queue; its result words leave through
// the output register. The front end takes one word per cycle while the queue is
// not full; the back end sends one result per cycle while rsp_tready is high.
// A four-entry queue lets the two ends stall independently; req_tready falls when it
// is full. Reset clears the stream state, the queue and the output valid flag.
// A stall on rsp_tready holds the result word and backs up through the queue.
`default_nettype none

module crlf_line_ending_normalizer_unit import crlf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: [7:0] in_byte
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rsp_tdata: [7:0] out_byte, [8] run_last, [10:9] status, [26:11] written_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: [0] byte_valid
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [COUNT_W-1:0]     csr_wdata
);

   logic            q_full, q_push, q_pop, q_valid;
   crlf_entry_type  q_in, q_head;
   crlf_result_type rsp;

   crlf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .in_ready   (req_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .push       (q_push),
      .push_entry (q_in)
   );

   crlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head)
   );

   crlf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the result word
   assign rsp_tdata = RSP_TDATA_W'({rsp.written_count, rsp.status, rsp.run_last,
                                    rsp.out_byte});
   assign rsp_tuser = rsp.byte_valid;
   assign rsp_tlast = rsp.stream_end;

endmodule

`default_nettype wire

// ----- rtl/crlf_checker.sv -----
// Port-level checks on the result channel of the normalizer, bound to the top level.
`default_nettype none

module crlf_checker (
   input wire        clock,
   input wire        reset,
   input wire [31:0] rsp_tdata,
   input wire        rsp_tuser,
   input wire        rsp_tlast,
   input wire        rsp_tvalid,
   input wire        rsp_tready
);

   // A status-only word always closes a stream
   a_status_only_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[7:0] == 8'h00))
      else $error("status-only word without stream end or with data");

   // Stream end is always the last word of its run
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[8])
      else $error("stream end without run last");

   // Status and count stay zero before the stream end
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[26:9] == 18'd0))
      else $error("status or count set on a non-final word");

   // Status code 3 is never sent
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:9] != 2'd3))
      else $error("undefined status code");

   // Stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

endmodule

bind crlf_line_ending_normalizer_unit crlf_checker u_crlf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

// ----- tb/crlf_line_ending_normalizer_unit_tb.sv -----
// Self-checking testbench of the CRLF line-ending normalizer: streams, capacity and checks.
`timescale 1ns / 100ps

import crlf_pkg::*;

// Predicts the result words of the normalizer and checks the ones it sends
class normalized_stream_board;
   logic [COUNT_W-1:0] capacity;
   crlf_phase_type     phase;
   bit                 held_cr;
   int unsigned        byte_count;
   bit                 overflowed;
   logic [7:0]         step_bytes[$];
   crlf_result_type    pending_words[$];
   int                 mismatches;

   function new();
      capacity = '1;
      mismatches = 0;
      end_stream();
   endfunction

   function void end_stream();
      phase = PH_SCAN;
      held_cr = 1'b0;
      byte_count = 0;
      overflowed = 1'b0;
   endfunction

   // Send one byte unless the capacity is used up
   function void emit(logic [7:0] b);
      if (overflowed) return;
      if (byte_count + 1 > capacity) begin
         overflowed = 1'b1;
         return;
      end
      step_bytes.push_back(b);
      byte_count++;
   endfunction

   function void emit_crlf();
      emit(CH_CR);
      emit(CH_LF);
   endfunction

   // Conversion mode: every lone CR, lone LF or CR LF pair becomes CR LF
   function void convert_byte(logic [7:0] b, logic last);
      if (held_cr) begin
         held_cr = 1'b0;
         emit_crlf();
         if (b == CH_LF) return;
      end
      if (b == CH_CR) begin
         if (last) emit_crlf();
         else held_cr = 1'b1;
      end else if (b == CH_LF) begin
         emit_crlf();
      end else begin
         emit(b);
      end
   endfunction

   // Work out the result words of one accepted input word
   function void predict_input(logic [7:0] b, logic last);
      crlf_result_type w;
      logic [1:0]      st;
      int              n;
      step_bytes.delete();
      case (phase)
         PH_SCAN: begin
            if (held_cr) begin
               held_cr = 1'b0;
               emit_crlf();
               if (b == CH_LF) begin
                  phase = PH_PASS;
               end else begin
                  phase = PH_CONV;
                  convert_byte(b, last);
               end
            end else if (b == CH_CR) begin
               if (last) begin
                  emit_crlf();
                  phase = PH_CONV;
               end else begin
                  held_cr = 1'b1;
               end
            end else if (b == CH_LF) begin
               emit_crlf();
               phase = PH_CONV;
            end else begin
               emit(b);
            end
         end
         PH_CONV: convert_byte(b, last);
         default: emit(b);
      endcase

      st = overflowed ? ST_OVF : (phase == PH_CONV ? ST_CONV : ST_NONE);
      n = step_bytes.size();
      for (int k = 0; k < n; k++) begin
         w = '0;
         w.out_byte = step_bytes[k];
         w.byte_valid = 1'b1;
         w.run_last = (k == n - 1);
         if (last && k == n - 1) begin
            w.stream_end = 1'b1;
            w.status = st;
            w.written_count = byte_count[WCOUNT_W-1:0];
         end
         pending_words.push_back(w);
      end
      // Status-only word when the final step sends no byte
      if (last && n == 0) begin
         w = '0;
         w.run_last = 1'b1;
         w.stream_end = 1'b1;
         w.status = st;
         w.written_count = byte_count[WCOUNT_W-1:0];
         pending_words.push_back(w);
      end
      if (last) end_stream();
   endfunction

   function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   // Check one accepted result word against the oldest prediction
   function void check_word(crlf_result_type got);
      crlf_result_type want;
      if (pending_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result word, byte %02h valid %0b end %0b", $time,
                     got.out_byte, got.byte_valid, got.stream_end);
         return;
      end
      want = pending_words.pop_front();
      compare("out_byte", want.out_byte, got.out_byte);
      compare("byte_valid", want.byte_valid, got.byte_valid);
      compare("run_last", want.run_last, got.run_last);
      compare("stream_end", want.stream_end, got.stream_end);
      compare("status", want.status, got.status);
      compare("written_count", want.written_count, got.written_count);
   endfunction
endclass

module crlf_line_ending_normalizer_unit_tb;

   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD  = 300;
   localparam int RANDOM_ITEMS = 210;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [7:0]             req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic [COUNT_W-1:0]     csr_wdata = '0;

   normalized_stream_board board = new();

   logic [7:0]  text[$];
   int          items_sent = 0;
   int          burst_left = 0;
   int          gap_max = 4;
   int          stall_mode = 0;
   int          holds_asked = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int unsigned rx_cycle = 0;

   crlf_line_ending_normalizer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: long hold on request, otherwise the current stall pattern
   always @(posedge clock) begin
      rx_cycle++;
      if (hold_left == 0 && holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((rx_cycle % 7) < 4);
         endcase
      end
   end

   // Check every accepted result word
   always @(posedge clock) begin
      crlf_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_byte = rsp_tdata[7:0];
         got.run_last = rsp_tdata[8];
         got.status = rsp_tdata[10:9];
         got.written_count = rsp_tdata[11 +: WCOUNT_W];
         got.byte_valid = rsp_tuser;
         got.stream_end = rsp_tlast;
         board.check_word(got);
      end
   end

   // Watchdog: end the run after a long stretch without any word accepted
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Offer one word, with a random gap before each burst when gap_max is nonzero
   task send_word(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         if (gap_max != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tdata <= b;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.predict_input(b, last);
      items_sent++;
   endtask

   task send_text();
      foreach (text[k]) send_word(text[k], k == text.size() - 1);
   endtask

   // Wait until every predicted word has arrived and the block has gone quiet
   task drain();
      req_tvalid <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task write_capacity(input logic [COUNT_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.capacity = value;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CH_CR || b == CH_LF) b = b ^ 8'h40;
      return b;
   endfunction

   // Text byte biased toward line endings
   function automatic logic [7:0] mixed_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return CH_CR;
      if (r < 6) return CH_LF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Build one random stream: mostly CR LF led or converting text, some plain noise
   task fill_random_text(input int max_len);
      int kind;
      int len;
      text.delete();
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, max_len);
      if (kind < 4) begin
         repeat ($urandom_range(0, 4)) text.push_back(plain_byte());
         text.push_back(CH_CR);
         text.push_back(CH_LF);
         repeat ($urandom_range(0, len)) text.push_back(mixed_byte());
      end else if (kind < 8) begin
         repeat (len) text.push_back(mixed_byte());
      end else if (kind == 8) begin
         repeat (len) text.push_back(plain_byte());
      end else begin
         repeat ($urandom_range(1, 2)) text.push_back(mixed_byte());
      end
   endtask

   function automatic logic [COUNT_W-1:0] pick_capacity();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return COUNT_W'($urandom_range(1, 4));
         3, 4: return COUNT_W'($urandom_range(5, 24));
         5: return COUNT_W'($urandom_range(0, 65535));
         default: return '1;
      endcase
   endfunction

   initial begin
      int phase_no;
      int start_items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed streams at the reset capacity
      stall_mode = 1;
      text = '{8'h61, CH_CR, CH_LF, 8'h62};
      send_text();
      text = '{CH_LF};
      send_text();
      text = '{CH_CR};
      send_text();
      text = '{8'h00, 8'hFF, 8'h7F, 8'h80};
      send_text();
      text = '{CH_CR, 8'h41, CH_CR, CH_CR, CH_LF, CH_LF};
      send_text();
      text = '{8'h78, CH_LF, CH_CR};
      send_text();

      // No room at all: a status-only word
      drain();
      write_capacity('0);
      text = '{8'h41};
      send_text();
      // Room runs out inside a CR LF pair
      drain();
      write_capacity(16'd3);
      text = '{CH_LF, CH_LF};
      send_text();
      drain();
      write_capacity(16'd4);
      text = '{CH_CR, CH_LF};
      send_text();

      // Random phases, each with its own capacity and idling
      phase_no = 0;
      start_items = items_sent;
      while (items_sent < start_items + RANDOM_ITEMS) begin
         drain();
         write_capacity(phase_no == 0 ? '1 : pick_capacity());
         stall_mode = $urandom_range(0, 3);
         gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (phase_no == 2) begin
            // Hold the receiver off while the sender keeps offering words
            write_capacity('1);
            stall_mode = 0;
            gap_max = 0;
            holds_asked++;
         end
         for (int s = 0; s < 4; s++) begin
            fill_random_text(phase_no == 2 ? 24 : 12);
            send_text();
         end
         phase_no++;
      end

      drain();
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.pending_words.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/crlf_pkg.sv
rtl/crlf_front.sv
rtl/crlf_queue.sv
rtl/crlf_back.sv
rtl/crlf_line_ending_normalizer_unit.sv
rtl/crlf_checker.sv
tb/crlf_line_ending_normalizer_unit_tb.sv
